// ===== design/comment_blanking_filter_defines.svh =====
// Assertion macros shared by the comment blanking filter RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef COMMENT_BLANKING_FILTER_DEFINES_SVH
`define COMMENT_BLANKING_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CBF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cbf_pkg.sv =====
// Package for the comment blanking filter: character codes, mode type and
// the structs passed between the filter modules. No dependencies.
package cbf_pkg;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Depth of the result queue; it must hold at least two entries.
	localparam int FIFO_DEPTH = 4;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_LINE   = 2'd1,
		MODE_BLOCK  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} item_t;

	// Up to two output bytes produced by one input byte.
	typedef struct packed {
		logic [1:0]      cnt;
		item_t [1:0]     res;
	} step_t;

endpackage

// ===== design/cbf_if.sv =====
// Valid/ready channel interfaces for the comment blanking filter.
// Depends on nothing; used by the top level and its submodules.
interface cbf_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       text_end;

	modport source (output valid, output text_byte, output text_end, input ready);
	modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

interface cbf_clean_if;
	logic       valid;
	logic       ready;
	logic [7:0] clean_byte;
	logic       clean_end;

	modport source (output valid, output clean_byte, output clean_end, input ready);
	modport sink (input valid, input clean_byte, input clean_end, output ready);
endinterface

// ===== design/comment_blanking_filter.sv =====
// Top level of the comment blanking filter.
// Depends on cbf_pkg, cbf_if, cbf_in_stage, cbf_step and cbf_out_fifo.
//
// Usage:
// - Input channel text carries one source byte per request (text_byte) and a
//   flag text_end on the final byte of a text. Output channel clean carries
//   the filtered bytes (clean_byte) with clean_end on the last byte of a text.
// - Comment bytes come out as spaces; the output has the same length as the
//   input. A slash, or a star inside a block comment, is held for one byte of
//   lookahead, so one input byte yields zero, one or two output bytes.
// - Path: an accepted byte waits in the input register, is filtered into the
//   result queue once the queue has room, and is offered on clean from there.
// - Throughput: one input byte per cycle while clean is ready. A step that
//   gives two bytes always follows one that held a byte back, so the result
//   queue absorbs the pair and the input side never waits on its own account.
// - When clean stalls, the queue holds up to FifoDepth bytes; text.ready drops
//   once fewer than two free entries remain and the input register is full.
// - Reset (arst_n low) empties the queue and returns to normal text mode with
//   nothing held; no clearing pass is needed.
module comment_blanking_filter #(
	parameter int FifoDepth = cbf_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	cbf_text_if.sink    text,
	cbf_clean_if.source clean
);

	logic           valid_s1;
	cbf_pkg::item_t item_s1;
	cbf_pkg::step_t step;
	logic           room;
	logic           fire;

	assign fire = valid_s1 && room;

	cbf_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.take     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	cbf_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.step    (step)
	);

	cbf_out_fifo #(
		.Depth (FifoDepth)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire),
		.step   (step),
		.room   (room),
		.clean  (clean)
	);

endmodule

// ===== design/cbf_in_stage.sv =====
// Input register of the comment blanking filter.
// Depends on cbf_pkg and cbf_text_if.
module cbf_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	cbf_text_if.sink        text,
	input  logic            take,
	output logic            valid_s1,
	output cbf_pkg::item_t  item_s1
);

	assign text.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			item_s1.data <= text.text_byte;
			item_s1.last <= text.text_end;
		end
	end

endmodule

// ===== design/cbf_step.sv =====
// Comment-mode state and per-byte filtering logic: one input byte gives
// zero, one or two output bytes. Depends on cbf_pkg and the assertion macros.
`include "comment_blanking_filter_defines.svh"

module cbf_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  cbf_pkg::item_t  item_s1,
	output cbf_pkg::step_t  step
);

	cbf_pkg::mode_t mode_q;
	logic           held_q;
	cbf_pkg::mode_t mode_d;
	logic           held_d;

	always_comb begin
		logic [1:0]          n;
		logic                consumed;
		cbf_pkg::item_t [1:0] res;
		logic [7:0]          b;

		b        = item_s1.data;
		n        = 2'd0;
		consumed = 1'b0;
		res      = '0;
		mode_d   = mode_q;
		held_d   = 1'b0;

		if (held_q) begin
			if (mode_q == cbf_pkg::MODE_NORMAL) begin
				if (b == cbf_pkg::CH_SLASH || b == cbf_pkg::CH_STAR) begin
					res[0].data = cbf_pkg::CH_SPACE;
					res[1].data = cbf_pkg::CH_SPACE;
					n           = 2'd2;
					mode_d      = (b == cbf_pkg::CH_SLASH) ? cbf_pkg::MODE_LINE
						: cbf_pkg::MODE_BLOCK;
					consumed    = 1'b1;
				end else begin
					res[0].data = cbf_pkg::CH_SLASH;
					n           = 2'd1;
				end
			end else begin
				if (b == cbf_pkg::CH_SLASH) begin
					res[0].data = cbf_pkg::CH_SPACE;
					res[1].data = cbf_pkg::CH_SPACE;
					n           = 2'd2;
					mode_d      = cbf_pkg::MODE_NORMAL;
					consumed    = 1'b1;
				end else begin
					res[0].data = cbf_pkg::CH_SPACE;
					n           = 2'd1;
				end
			end
		end

		if (!consumed) begin
			unique case (mode_d)
				cbf_pkg::MODE_NORMAL: begin
					if (b == cbf_pkg::CH_SLASH) begin
						held_d = 1'b1;
					end else begin
						res[n[0]].data = b;
						n              = n + 2'd1;
					end
				end
				cbf_pkg::MODE_BLOCK: begin
					if (b == cbf_pkg::CH_STAR) begin
						held_d = 1'b1;
					end else begin
						res[n[0]].data = cbf_pkg::CH_SPACE;
						n              = n + 2'd1;
					end
				end
				default: begin
					// Line comment: the ending newline passes and closes the comment.
					if (b == cbf_pkg::CH_NL) begin
						res[n[0]].data = b;
						mode_d         = cbf_pkg::MODE_NORMAL;
					end else begin
						res[n[0]].data = cbf_pkg::CH_SPACE;
					end
					n = n + 2'd1;
				end
			endcase
		end

		if (item_s1.last) begin
			// End of text flushes a held byte and returns to normal text.
			if (held_d) begin
				res[n[0]].data = (mode_d == cbf_pkg::MODE_NORMAL) ? cbf_pkg::CH_SLASH
					: cbf_pkg::CH_SPACE;
				n              = n + 2'd1;
			end
			held_d = 1'b0;
			mode_d = cbf_pkg::MODE_NORMAL;
			if (n == 2'd2) begin
				res[1].last = 1'b1;
			end else if (n == 2'd1) begin
				res[0].last = 1'b1;
			end
		end

		step.cnt = n;
		step.res = res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cbf_pkg::MODE_NORMAL;
			held_q <= 1'b0;
		end else if (fire) begin
			mode_q <= mode_d;
			held_q <= held_d;
		end
	end

	`CBF_ASSERT_NEXT(a_end_resets_mode, fire && item_s1.last,
		mode_q == cbf_pkg::MODE_NORMAL && !held_q, "end of text did not restore normal mode")
	`CBF_ASSERT_NOW(a_end_gives_output, fire && item_s1.last,
		step.cnt != 2'd0, "end of text produced no output byte")
	`CBF_ASSERT_NOW(a_held_mode, held_q,
		mode_q != cbf_pkg::MODE_LINE, "byte held inside a line comment")
	`CBF_ASSERT_NOW(a_count_range, fire,
		step.cnt != 2'd3, "more than two output bytes for one input byte")

endmodule

// ===== design/cbf_out_fifo.sv =====
// Result queue of the comment blanking filter: takes up to two bytes per
// cycle, delivers one while clean is ready. Uses cbf_pkg, cbf_clean_if.
module cbf_out_fifo #(
	parameter int Depth = cbf_pkg::FIFO_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cbf_pkg::step_t  step,
	output logic            room,
	cbf_clean_if.source     clean
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

	cbf_pkg::item_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic [PtrW-1:0] wr_ptr_p1;
	logic [PtrW-1:0] wr_ptr_p2;
	logic [PtrW-1:0] rd_ptr_p1;
	logic [1:0]      push_cnt;
	logic            pop;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == LastPtr) ? '0 : p + PtrW'(1);
	endfunction

	assign wr_ptr_p1 = ptr_inc(wr_ptr_q);
	assign wr_ptr_p2 = ptr_inc(wr_ptr_p1);
	assign rd_ptr_p1 = ptr_inc(rd_ptr_q);
	assign push_cnt  = push ? step.cnt : 2'd0;
	assign pop       = clean.valid && clean.ready;
	assign room      = count_q <= CntW'(Depth - 2);

	assign clean.valid      = count_q != '0;
	assign clean.clean_byte = mem_q[rd_ptr_q].data;
	assign clean.clean_end  = mem_q[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= step.res[0];
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= step.res[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			unique case (push_cnt)
				2'd1:    wr_ptr_q <= wr_ptr_p1;
				2'd2:    wr_ptr_q <= wr_ptr_p2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= rd_ptr_p1;
			end
			count_q <= count_q + CntW'(push_cnt) - CntW'(pop);
		end
	end

endmodule
